/* design/ple_pkg.sv */
// Shared types and constants for the positional list engine.
`timescale 1ns / 1ps
package ple_pkg;
  localparam int unsigned DefCapacity = 32;

  typedef enum logic [3:0] {
    OP_CLEAR  = 4'd0,
    OP_APPEND = 4'd1,
    OP_LENGTH = 4'd2,
    OP_LOCATE = 4'd3,
    OP_GET    = 4'd4,
    OP_INSERT = 4'd5,
    OP_DELETE = 4'd6,
    OP_SORT   = 4'd7,
    OP_REVERSE = 4'd8,
    OP_DUMP   = 4'd9
  } op_e;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BADPOS   = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  // Cell command, broadcast to every cell of the row.
  typedef enum logic [2:0] {
    CC_HOLD   = 3'd0,
    CC_INSERT = 3'd1,  // cells above index take left neighbor, index cell loads value
    CC_DELETE = 3'd2,  // cells at or above index take right neighbor
    CC_SWAPEV = 3'd3,  // odd-even sort, even pairs
    CC_SWAPOD = 3'd4,  // odd-even sort, odd pairs
    CC_ROTL   = 3'd5,  // rotate first len entries left by one (circular read-out)
    CC_REVST  = 3'd6   // reverse step: cells below idx-1 take right neighbor, cell idx-1 takes head
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e   cmd;
    logic [6:0]  idx;
    logic [6:0]  len;
    logic [7:0]  val;
  } cell_ctl_t;
endpackage

/* design/positional_list_engine.sv */
// Top level of the positional list engine: control sequencer and row of cells.
`timescale 1ns / 1ps
// Usage:
//  - Requests enter on s_axis (opcode, value, position in tdata); results leave
//    on m_axis (status, position_res, element, count in tdata, last on tlast).
//  - The list lives in a row of Capacity cells; each cell talks to its
//    neighbors every cycle. Insert and delete shift the row as they are taken.
//  - Sort is an odd-even transposition over the row.
//  - Reverse rotates shrinking prefixes.
//  - Sort, reverse and dump read the list out by rotating it through cell 0,
//    one result per cycle when the receiver takes it.
//  - Locate first counts matches in one full turn, then reports them in a
//    second turn.
//  - One request is in work at a time.
//  - A stalled receiver freezes the read-out; the result register holds.
//  - Reset (rst_ni low, asynchronous) empties the list and the result register.
//  - Unused opcodes are taken and dropped with no result.
module positional_list_engine import ple_pkg::*; #(
  parameter int unsigned Capacity = DefCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [3:0] opcode, [11:4] value, [18:12] position
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [2:0] status, [9:3] position_res,
                                      // [17:10] element, [24:18] count
  output logic        m_axis_tlast
);
  localparam logic [6:0] Cap = 7'(Capacity);

  typedef enum logic [2:0] {S_IDLE, S_SORT, S_REV, S_SCAN, S_OUT, S_WAIT} state_e;

  state_e      state_q;
  logic [3:0]  op_q;
  logic [7:0]  val_q;
  logic [6:0]  len_q, cnt_q, nmatch_q, seen_q;
  cell_ctl_t   ctl;
  logic [7:0]  elems [Capacity];

  // result register
  logic        ovalid_q, olast_q;
  logic [2:0]  ost_q;
  logic [6:0]  opos_q, ocnt_q;
  logic [7:0]  oel_q;

  logic [3:0]  in_op;
  logic [7:0]  in_val;
  logic [6:0]  in_pos;
  assign in_op  = s_axis_tdata[3:0];
  assign in_val = s_axis_tdata[11:4];
  assign in_pos = s_axis_tdata[18:12];

  assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {7'd0, ocnt_q, oel_q, opos_q, ost_q};

  logic take, out_free, match0;
  assign take     = s_axis_tvalid && s_axis_tready;
  assign out_free = !ovalid_q || m_axis_tready;
  assign match0   = elems[0] == val_q;

  // cell commands follow state and request
  always_comb begin
    ctl = '{cmd: CC_HOLD, idx: 7'd0, len: len_q, val: in_val};
    priority case (1'b1)
      take && in_op == OP_INSERT && in_pos >= 7'd1 && in_pos <= len_q + 7'd1
        && len_q < Cap: begin
        ctl.cmd = CC_INSERT; ctl.idx = in_pos - 7'd1;
      end
      take && in_op == OP_APPEND && len_q < Cap: begin
        ctl.cmd = CC_INSERT; ctl.idx = len_q;
      end
      take && in_op == OP_DELETE && in_pos >= 7'd1 && in_pos <= len_q: begin
        ctl.cmd = CC_DELETE; ctl.idx = in_pos - 7'd1;
      end
      state_q == S_SORT: ctl.cmd = cnt_q[0] ? CC_SWAPOD : CC_SWAPEV;
      state_q == S_REV: begin
        ctl.cmd = CC_REVST; ctl.idx = len_q - cnt_q;
      end
      (state_q == S_SCAN || state_q == S_OUT) && out_free: ctl.cmd = CC_ROTL;
      default: ctl.cmd = CC_HOLD;
    endcase
  end

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    ple_cell #(.Index(g)) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .left_i (elems[(g == 0) ? 0 : g - 1]),
      .right_i(elems[(g == Capacity - 1) ? g : g + 1]),
      .head_i (elems[0]),
      .elem_o (elems[g])
    );
  end

  // get reads position in cell; a mux over the row
  logic [7:0] get_el;
  assign get_el = elems[in_pos[$clog2(Capacity)-1:0] - 1'b1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      len_q    <= '0;
      ovalid_q <= 1'b0;
      cnt_q    <= '0;
      nmatch_q <= '0;
      seen_q   <= '0;
      op_q     <= '0;
      val_q    <= '0;
      olast_q  <= 1'b0;
      ost_q    <= ST_OK;
      opos_q   <= '0;
      oel_q    <= '0;
      ocnt_q   <= '0;
    end else begin
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (take) begin
          op_q <= in_op; val_q <= in_val;
          cnt_q <= '0; nmatch_q <= '0; seen_q <= '0;
          ost_q <= ST_OK; opos_q <= '0; oel_q <= '0; olast_q <= 1'b1; ocnt_q <= len_q;
          unique case (in_op)
            OP_CLEAR: begin len_q <= '0; ocnt_q <= '0; ovalid_q <= 1'b1; end
            OP_LENGTH: ovalid_q <= 1'b1;
            OP_APPEND: begin
              ovalid_q <= 1'b1;
              if (len_q >= Cap) ost_q <= ST_FULL;
              else begin
                len_q <= len_q + 7'd1; ocnt_q <= len_q + 7'd1;
                opos_q <= len_q + 7'd1; oel_q <= in_val;
              end
            end
            OP_GET: begin
              ovalid_q <= 1'b1;
              if (in_pos < 7'd1 || in_pos > len_q) ost_q <= ST_BADPOS;
              else begin opos_q <= in_pos; oel_q <= get_el; end
            end
            OP_INSERT: begin
              ovalid_q <= 1'b1;
              if (in_pos < 7'd1 || in_pos > len_q + 7'd1) ost_q <= ST_BADPOS;
              else if (len_q >= Cap) ost_q <= ST_FULL;
              else begin
                len_q <= len_q + 7'd1; ocnt_q <= len_q + 7'd1;
                opos_q <= in_pos; oel_q <= in_val;
              end
            end
            OP_DELETE: begin
              ovalid_q <= 1'b1;
              if (in_pos < 7'd1 || in_pos > len_q) ost_q <= ST_BADPOS;
              else begin
                len_q <= len_q - 7'd1; ocnt_q <= len_q - 7'd1;
                opos_q <= in_pos; oel_q <= get_el;
              end
            end
            OP_LOCATE: begin
              if (len_q == 7'd0) begin ost_q <= ST_NOTFOUND; ovalid_q <= 1'b1; end
              else state_q <= S_SCAN;
            end
            OP_SORT, OP_REVERSE, OP_DUMP: begin
              if (len_q == 7'd0) begin ost_q <= ST_EMPTY; ovalid_q <= 1'b1; end
              else state_q <= (in_op == OP_SORT) ? S_SORT
                            : (in_op == OP_REVERSE) ? S_REV : S_OUT;
            end
            default: ;
          endcase
        end
        S_SORT, S_REV: begin
          if (cnt_q + 7'd1 >= len_q) begin cnt_q <= '0; state_q <= S_OUT; end
          else cnt_q <= cnt_q + 7'd1;
        end
        // first pass counts matches, rotating a full turn
        S_SCAN: if (out_free) begin
          if (match0) nmatch_q <= nmatch_q + 7'd1;
          if (cnt_q + 7'd1 >= len_q) begin
            cnt_q <= '0;
            if (nmatch_q == 7'd0 && !match0) begin
              ost_q <= ST_NOTFOUND; olast_q <= 1'b1; ovalid_q <= 1'b1;
              state_q <= S_WAIT;
            end else state_q <= S_OUT;
          end else cnt_q <= cnt_q + 7'd1;
        end
        // read-out turn; locate emits matches only
        S_OUT: if (out_free) begin
          if (op_q == OP_LOCATE) begin
            if (match0) begin
              ovalid_q <= 1'b1; ost_q <= ST_OK; opos_q <= cnt_q + 7'd1; oel_q <= val_q;
              olast_q <= (seen_q + 7'd1 == nmatch_q);
              seen_q <= seen_q + 7'd1;
            end
          end else begin
            ovalid_q <= 1'b1; ost_q <= ST_OK; opos_q <= cnt_q + 7'd1; oel_q <= elems[0];
            olast_q <= (cnt_q + 7'd1 == len_q);
          end
          if (cnt_q + 7'd1 >= len_q) state_q <= S_WAIT;
          cnt_q <= cnt_q + 7'd1;
        end
        S_WAIT: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

/* design/ple_cell.sv */
// One list cell: holds an element and exchanges it with its neighbors.
`timescale 1ns / 1ps
module ple_cell import ple_pkg::*; #(
  parameter int unsigned Index = 0
) (
  input  logic       clk_i,
  input  cell_ctl_t  ctl_i,
  input  logic [7:0] left_i,   // element of cell Index-1
  input  logic [7:0] right_i,  // element of cell Index+1
  input  logic [7:0] head_i,   // element of cell 0
  output logic [7:0] elem_o
);
  localparam logic [6:0] Idx = 7'(Index);
  logic [7:0] elem_q, elem_d;
  logic       odd_cell;

  assign odd_cell = Idx[0];
  assign elem_o   = elem_q;

  // signed compare: element greater than a neighbor
  function automatic logic gt(input logic [7:0] a, input logic [7:0] b);
    gt = $signed(a) > $signed(b);
  endfunction

  always_comb begin
    elem_d = elem_q;
    unique case (ctl_i.cmd)
      CC_INSERT: begin
        if (Idx == ctl_i.idx) elem_d = ctl_i.val;
        else if (Idx > ctl_i.idx) elem_d = left_i;
      end
      CC_DELETE: if (Idx >= ctl_i.idx) elem_d = right_i;
      CC_SWAPEV, CC_SWAPOD: begin
        // pair starts at even cells for EV, odd cells for OD
        if (odd_cell == (ctl_i.cmd == CC_SWAPOD)) begin
          if (Idx + 7'd1 < ctl_i.len && gt(elem_q, right_i)) elem_d = right_i;
        end else if (Idx != 7'd0 && Idx < ctl_i.len && gt(left_i, elem_q)) begin
          elem_d = left_i;
        end
      end
      CC_ROTL: begin
        if (Idx + 7'd1 < ctl_i.len) elem_d = right_i;
        else if (Idx + 7'd1 == ctl_i.len) elem_d = head_i;
      end
      CC_REVST: begin
        // rotate the prefix [0, idx) left; reversing is len such steps on shrinking prefix
        if (Idx + 7'd1 < ctl_i.idx) elem_d = right_i;
        else if (Idx + 7'd1 == ctl_i.idx) elem_d = head_i;
      end
      default: elem_d = elem_q;
    endcase
  end

  always_ff @(posedge clk_i) elem_q <= elem_d;
endmodule
